/* src/bfa_pkg.sv */
`default_nettype none
package bfa_pkg;

  // command field
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // configuration register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 14;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_START,
    OP_STEP,
    OP_MERGE,
    OP_SPLIT,
    OP_MARK,
    OP_FREE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     set_sel;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_FIT,
    S_MERGE,
    S_ALLOC
  } state_t;

endpackage
`default_nettype wire

/* src/bfa_cell.sv */
`default_nettype none
module bfa_cell
  import bfa_pkg::*;
#(
  parameter int         OFF_W    = 13,
  parameter int         LEN_W    = 14,
  parameter bit         FIRST    = 1'b0,
  parameter logic [LEN_W-1:0] INIT_LEN = '0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctl_t        ctl,
  input  wire logic [LEN_W-1:0] init_len,
  input  wire logic [LEN_W-1:0] req_len,
  input  wire logic [OFF_W-1:0] split_off,
  input  wire logic [LEN_W-1:0] split_len,
  input  wire logic             tok_left,
  input  wire logic             sel_left,
  input  wire logic [OFF_W-1:0] left_off,
  input  wire logic [LEN_W-1:0] left_len,
  input  wire logic             left_used,
  input  wire logic             left_valid,
  input  wire logic [OFF_W-1:0] right_off,
  input  wire logic [LEN_W-1:0] right_len,
  input  wire logic             right_used,
  input  wire logic             right_valid,
  output logic      [OFF_W-1:0] off,
  output logic      [LEN_W-1:0] len,
  output logic                  used,
  output logic                  valid,
  output logic                  tok,
  output logic                  sel,
  output logic                  merge_ok
);

  logic after;   // right of the selected cell
  logic right;   // right of the token

  assign merge_ok = tok & valid & ~used & right_valid & ~right_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= FIRST;
      used  <= 1'b0;
      off   <= '0;
      len   <= INIT_LEN;
      tok   <= 1'b0;
      sel   <= 1'b0;
      after <= 1'b0;
      right <= 1'b0;
    end else begin
      case (ctl.op)
        OP_INIT: begin
          valid <= FIRST;
          used  <= 1'b0;
          off   <= '0;
          len   <= init_len;
          tok   <= 1'b0;
          sel   <= 1'b0;
          after <= 1'b0;
          right <= 1'b0;
        end
        OP_START: begin
          tok   <= FIRST;
          right <= ~FIRST;
          sel   <= 1'b0;
          after <= 1'b0;
        end
        OP_STEP: begin
          tok   <= tok_left;
          right <= right & ~tok_left;
          if (ctl.set_sel) begin
            sel   <= tok;
            after <= right;
          end
        end
        OP_MERGE: begin
          if (tok) begin
            len <= LEN_W'(len + right_len);
          end else if (right) begin
            off   <= right_off;
            len   <= right_len;
            used  <= right_used;
            valid <= right_valid;
          end
        end
        OP_SPLIT: begin
          if (sel) begin
            len  <= req_len;
            used <= 1'b1;
          end else if (after) begin
            if (sel_left) begin
              off   <= split_off;
              len   <= split_len;
              used  <= 1'b0;
              valid <= 1'b1;
            end else begin
              off   <= left_off;
              len   <= left_len;
              used  <= left_used;
              valid <= left_valid;
            end
          end
        end
        OP_MARK: begin
          if (sel) used <= 1'b1;
        end
        OP_FREE: begin
          if (tok) used <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/bfa_ctrl.sv */
`default_nettype none
module bfa_ctrl
  import bfa_pkg::*;
#(
  parameter int ARENA_BYTES = 8192,
  parameter int OFF_W       = 13,
  parameter int LEN_W       = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              command,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [ADDR_W-1:0] req_address,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire logic [OFF_W-1:0]  bus_off,
  input  wire logic [LEN_W-1:0]  bus_len,
  input  wire logic              bus_used,
  input  wire logic              bus_valid,
  input  wire logic              merge_any,
  input  wire logic              full,
  output logic                   busy,
  output logic                   done,
  output logic      [ADDR_W-1:0] result_address,
  output logic      [2:0]        status,
  output cell_ctl_t              ctl,
  output logic      [LEN_W-1:0]  init_len,
  output logic      [LEN_W-1:0]  req_len,
  output logic      [OFF_W-1:0]  split_off,
  output logic      [LEN_W-1:0]  split_len
);

  state_t            state, state_next;
  logic [ADDR_W-1:0] base, base_next;
  logic [LEN_W-1:0]  free_bytes, free_bytes_next;
  logic [LEN_W-1:0]  sz, sz_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic              merged, merged_next;
  logic              have_best, have_best_next;
  logic [LEN_W-1:0]  best_len, best_len_next;
  logic [OFF_W-1:0]  best_off, best_off_next;
  logic              done_next;
  logic [ADDR_W-1:0] result_address_next;
  logic [2:0]        status_next;
  logic [SIZE_W-1:0] cfg_size;
  logic [ADDR_W-1:0] bus_addr;

  assign busy      = (state != S_IDLE);
  assign req_len   = sz;
  assign split_off = OFF_W'(32'(best_off) + 32'(sz));
  assign split_len = LEN_W'(best_len - sz);
  assign bus_addr  = base + ADDR_W'(bus_off);

  // clamp written arena size to 1..ARENA_BYTES
  always_comb begin
    cfg_size = cfg_data[SIZE_W-1:0];
    if (cfg_size == '0) cfg_size = SIZE_W'(1);
    if (32'(cfg_size) > ARENA_BYTES) cfg_size = SIZE_W'(ARENA_BYTES);
    init_len = LEN_W'(cfg_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      base           <= '0;
      free_bytes     <= LEN_W'(ARENA_BYTES);
      done           <= 1'b0;
      merged         <= 1'b0;
      have_best      <= 1'b0;
    end else begin
      state          <= state_next;
      base           <= base_next;
      free_bytes     <= free_bytes_next;
      done           <= done_next;
      merged         <= merged_next;
      have_best      <= have_best_next;
    end
    sz             <= sz_next;
    addr           <= addr_next;
    best_len       <= best_len_next;
    best_off       <= best_off_next;
    result_address <= result_address_next;
    status         <= status_next;
  end

  always_comb begin
    state_next          = state;
    base_next           = base;
    free_bytes_next     = free_bytes;
    sz_next             = sz;
    addr_next           = addr;
    merged_next         = merged;
    have_best_next      = have_best;
    best_len_next       = best_len;
    best_off_next       = best_off;
    done_next           = 1'b0;
    result_address_next = result_address;
    status_next         = status;
    ctl.op              = OP_HOLD;
    ctl.set_sel         = 1'b0;

    case (state)
      S_IDLE: begin
        if (cfg_we) begin
          if (cfg_index == REG_BASE) begin
            base_next = cfg_data;
          end else begin
            ctl.op          = OP_INIT;
            free_bytes_next = init_len;
          end
        end else if (start) begin
          sz_next             = LEN_W'(req_size);
          addr_next           = req_address;
          merged_next         = 1'b0;
          have_best_next      = 1'b0;
          result_address_next = '0;
          if (command == CMD_RELEASE) begin
            ctl.op     = OP_START;
            state_next = S_REL;
          end else if (req_size == '0 || 32'(req_size) > ARENA_BYTES ||
                       32'(req_size) > 32'(free_bytes)) begin
            status_next = ST_BAD_SIZE;
            done_next   = 1'b1;
          end else begin
            ctl.op     = OP_START;
            state_next = S_FIT;
          end
        end
      end

      S_REL: begin
        if (!bus_valid) begin
          status_next = ST_NOT_FND;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (bus_used && bus_addr == addr) begin
          ctl.op          = OP_FREE;
          free_bytes_next = LEN_W'(free_bytes + bus_len);
          status_next     = ST_OK;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.op = OP_STEP;
        end
      end

      S_FIT: begin
        if (!bus_valid) begin
          if (have_best) begin
            state_next = S_ALLOC;
          end else if (!merged) begin
            ctl.op      = OP_START;
            merged_next = 1'b1;
            state_next  = S_MERGE;
          end else begin
            status_next = ST_NO_FIT;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          ctl.op = OP_STEP;
          if (!bus_used && bus_len == sz) begin
            ctl.set_sel    = 1'b1;
            have_best_next = 1'b1;
            best_len_next  = bus_len;
            best_off_next  = bus_off;
            state_next     = S_ALLOC;
          end else if (!bus_used && bus_len > sz &&
                       (!have_best || bus_len < best_len)) begin
            ctl.set_sel    = 1'b1;
            have_best_next = 1'b1;
            best_len_next  = bus_len;
            best_off_next  = bus_off;
          end
        end
      end

      S_MERGE: begin
        if (!bus_valid) begin
          ctl.op     = OP_START;
          state_next = S_FIT;
        end else if (merge_any) begin
          ctl.op = OP_MERGE;
        end else begin
          ctl.op = OP_STEP;
        end
      end

      S_ALLOC: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (best_len > sz && full) begin
          status_next = ST_FULL;
        end else begin
          ctl.op              = (best_len > sz) ? OP_SPLIT : OP_MARK;
          free_bytes_next     = LEN_W'(free_bytes - sz);
          status_next         = ST_OK;
          result_address_next = base + ADDR_W'(best_off);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/best_fit_arena_allocator.sv */
`default_nettype none
// Best-fit arena allocator. The arena is a table of chunks held in a row of
// MAX_CHUNKS cells in address order; a token walks the row one cell a cycle,
// holding while a merge is made, and the token cell's chunk is read by the
// controller. A word is accepted when start is high, cfg_we is low and busy
// is low; exactly one result word follows, shown on result_address/status
// for the single cycle that done is high. The receiver cannot stall: done is
// never held, so sample it when it comes. A bad-size allocate is answered
// from idle without raising busy; a release walks the row until it meets the
// used chunk at req_address or runs off the valid cells; an allocate scans
// the row, and if nothing fits it runs a merge pass (one merge or step each
// cycle) and a rescan. Configuration writes are taken only while busy is low.
module best_fit_arena_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_CHUNKS  = 64,
  parameter int ARENA_BYTES = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              command,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [ADDR_W-1:0] req_address,
  // result channel
  output logic                   done,
  output logic      [ADDR_W-1:0] result_address,
  output logic      [2:0]        status,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  localparam int OFF_W = $clog2(ARENA_BYTES);
  localparam int LEN_W = $clog2(ARENA_BYTES + 1);

  cell_ctl_t        ctl;
  logic [LEN_W-1:0] init_len, req_len, split_len;
  logic [OFF_W-1:0] split_off;

  logic [OFF_W-1:0] c_off   [MAX_CHUNKS];
  logic [LEN_W-1:0] c_len   [MAX_CHUNKS];
  logic             c_used  [MAX_CHUNKS];
  logic             c_valid [MAX_CHUNKS];
  logic             c_tok   [MAX_CHUNKS];
  logic             c_sel   [MAX_CHUNKS];
  logic             c_merge [MAX_CHUNKS];

  // token cell drives the shared read bus
  logic [OFF_W-1:0] bus_off;
  logic [LEN_W-1:0] bus_len;
  logic             bus_used, bus_valid, merge_any;

  always_comb begin
    bus_off   = '0;
    bus_len   = '0;
    bus_used  = 1'b0;
    bus_valid = 1'b0;
    merge_any = 1'b0;
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      bus_off   = bus_off   | (c_off[k] & {OFF_W{c_tok[k]}});
      bus_len   = bus_len   | (c_len[k] & {LEN_W{c_tok[k]}});
      bus_used  = bus_used  | (c_used[k] & c_tok[k]);
      bus_valid = bus_valid | (c_valid[k] & c_tok[k]);
      merge_any = merge_any | c_merge[k];
    end
  end

  for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_cell
    logic [OFF_W-1:0] l_off, r_off;
    logic [LEN_W-1:0] l_len, r_len;
    logic             l_used, l_valid, l_tok, l_sel, r_used, r_valid;

    if (k == 0) begin : g_head
      assign l_off   = '0;
      assign l_len   = '0;
      assign l_used  = 1'b0;
      assign l_valid = 1'b0;
      assign l_tok   = 1'b0;
      assign l_sel   = 1'b0;
    end else begin : g_mid
      assign l_off   = c_off[k-1];
      assign l_len   = c_len[k-1];
      assign l_used  = c_used[k-1];
      assign l_valid = c_valid[k-1];
      assign l_tok   = c_tok[k-1];
      assign l_sel   = c_sel[k-1];
    end

    if (k == MAX_CHUNKS - 1) begin : g_tail
      assign r_off   = '0;
      assign r_len   = '0;
      assign r_used  = 1'b0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_off   = c_off[k+1];
      assign r_len   = c_len[k+1];
      assign r_used  = c_used[k+1];
      assign r_valid = c_valid[k+1];
    end

    bfa_cell #(
      .OFF_W    (OFF_W),
      .LEN_W    (LEN_W),
      .FIRST    (k == 0),
      .INIT_LEN (LEN_W'(ARENA_BYTES))
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .init_len    (init_len),
      .req_len     (req_len),
      .split_off   (split_off),
      .split_len   (split_len),
      .tok_left    (l_tok),
      .sel_left    (l_sel),
      .left_off    (l_off),
      .left_len    (l_len),
      .left_used   (l_used),
      .left_valid  (l_valid),
      .right_off   (r_off),
      .right_len   (r_len),
      .right_used  (r_used),
      .right_valid (r_valid),
      .off         (c_off[k]),
      .len         (c_len[k]),
      .used        (c_used[k]),
      .valid       (c_valid[k]),
      .tok         (c_tok[k]),
      .sel         (c_sel[k]),
      .merge_ok    (c_merge[k])
    );
  end

  bfa_ctrl #(
    .ARENA_BYTES (ARENA_BYTES),
    .OFF_W       (OFF_W),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .command        (command),
    .req_size       (req_size),
    .req_address    (req_address),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bus_off        (bus_off),
    .bus_len        (bus_len),
    .bus_used       (bus_used),
    .bus_valid      (bus_valid),
    .merge_any      (merge_any),
    .full           (c_valid[MAX_CHUNKS-1]),
    .busy           (busy),
    .done           (done),
    .result_address (result_address),
    .status         (status),
    .ctl            (ctl),
    .init_len       (init_len),
    .req_len        (req_len),
    .split_off      (split_off),
    .split_len      (split_len)
  );

endmodule
`default_nettype wire
